### hw/rtl/gfr_pkg.sv
// gfr_pkg: types, constants and the pad function of the grid footprint rasterizer
// used by gfr_ctrl, gfr_dpath and grid_footprint_rasterizer; no dependencies
package gfr_pkg;

	localparam int CELL_W  = 23;
	localparam int CNT_W   = 13;
	localparam int POS_W   = 24;
	localparam int SIZE_W  = 23;
	localparam int IDX_W   = 16;
	localparam int MAX_PAD = 3;
	localparam int PAD_W   = 2;
	localparam int OFF_W   = PAD_W + 1;
	localparam int THR_W   = CELL_W + 3;
	localparam int PROD_W  = CELL_W + CNT_W;
	localparam int NUM_W   = PROD_W + 2;
	localparam int MAG_W   = PROD_W + 1;
	localparam int DIV_STEPS = MAG_W;
	localparam int STEP_W  = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W = 2;
	localparam int IN_W    = 96;
	localparam int OUT_W   = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_CELL_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 2'd2;

	localparam logic [CELL_W-1:0] CELL_RESET = 23'd256;
	localparam logic [CNT_W-1:0]  COLS_RESET = 13'd256;
	localparam logic [CNT_W-1:0]  ROWS_RESET = 13'd256;

	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Z = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} gfr_state_t;

	typedef struct packed {
		logic cap;
		logic mul;
		logic load;
		logic step;
		logic fin;
		logic advance;
		logic axis;
	} gfr_cmd_t;

	typedef struct packed {
		logic last;
	} gfr_stat_t;

	typedef struct packed {
		logic [PAD_W-1:0] pad;
		logic             clip;
	} gfr_pad_t;

	// pad = floor((size-c)/(2c)) + 1 when size > c, else 0; clamped to MAX_PAD with clip set, found by threshold compares
	function automatic gfr_pad_t pad_calc(input logic [SIZE_W-1:0] size,
			input logic [CELL_W-1:0] c);
		gfr_pad_t         res;
		logic [THR_W-1:0] d;
		logic [THR_W-1:0] thr;
		logic [PAD_W-1:0] q;
		q = '0;
		d = THR_W'(size) - THR_W'(c);
		for (int j = 1; j <= MAX_PAD; j++) begin
			thr = THR_W'(c) * THR_W'(2 * j);
			if (d >= thr)
				q = q + 1'b1;
		end
		if (size <= c) begin
			res.pad  = '0;
			res.clip = 1'b0;
		end else if (q >= PAD_W'(MAX_PAD)) begin
			res.pad  = PAD_W'(MAX_PAD);
			res.clip = 1'b1;
		end else begin
			res.pad  = q + 1'b1;
			res.clip = 1'b0;
		end
		return res;
	endfunction

endpackage

### hw/rtl/gfr_ctrl.sv
// gfr_ctrl: sequencer of the grid footprint rasterizer
// depends on gfr_pkg; drives gfr_dpath through gfr_cmd_t
module gfr_ctrl import gfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  gfr_stat_t stat,
	output gfr_cmd_t  cmd
);

	gfr_state_t        state_q, state_d;
	logic              axis_q;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= AXIS_X;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: axis_q <= AXIS_X;
				ST_LOAD: step_q <= '0;
				ST_DIV:  step_q <= step_q + 1'b1;
				ST_FIN:  axis_q <= AXIS_Z;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_MUL;
			ST_MUL:  state_d = ST_LOAD;
			ST_LOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1))
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (axis_q == AXIS_X)
					state_d = ST_MUL;
				else
					state_d = ST_EMIT;
			end
			ST_EMIT: if (m_tready && stat.last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		cmd         = '0;
		cmd.axis    = axis_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.cap  = s_tvalid;
			end
			ST_MUL:  cmd.mul  = 1'b1;
			ST_LOAD: cmd.load = 1'b1;
			ST_DIV:  cmd.step = 1'b1;
			ST_FIN:  cmd.fin  = 1'b1;
			ST_EMIT: begin
				m_tvalid    = 1'b1;
				cmd.advance = m_tready;
			end
			default: ;
		endcase
	end

endmodule

### hw/rtl/gfr_dpath.sv
// gfr_dpath: config registers, pad compare, shared multiplier, serial divider, cell walk
// depends on gfr_pkg; controlled by gfr_ctrl through gfr_cmd_t
module gfr_dpath import gfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CELL_W-1:0]    cfg_data,
	input  logic                 in_type,
	input  logic [POS_W-1:0]     in_pos_x,
	input  logic [POS_W-1:0]     in_pos_z,
	input  logic [SIZE_W-1:0]    in_size_x,
	input  logic [SIZE_W-1:0]    in_size_z,
	input  gfr_cmd_t             cmd,
	output gfr_stat_t            stat,
	output logic [IDX_W-1:0]     cell_row,
	output logic [IDX_W-1:0]     cell_col,
	output logic                 clipped
);

	logic [CELL_W-1:0] cell_q;
	logic [CNT_W-1:0]  cols_q, rows_q;
	logic [CELL_W-1:0] c_eff;

	logic              type_q;
	logic [POS_W-1:0]  posx_q, posz_q;
	logic [SIZE_W-1:0] sizex_q, sizez_q;

	logic [PAD_W-1:0]  padx_q, padz_q;
	logic              clip_q;
	logic [PROD_W-1:0] prod_q;
	logic              neg_q;
	logic [CELL_W-1:0] rem_q;
	logic [MAG_W-1:0]  qd_q;
	logic [IDX_W-1:0]  colbase_q, row_q, col_q;
	logic [OFF_W-1:0]  roff_q, coff_q;

	gfr_pad_t          px, pz;
	logic [CNT_W-1:0]  k;
	logic [NUM_W-1:0]  num;
	logic [MAG_W-1:0]  mag;
	logic [CELL_W:0]   rem_sh;
	logic              ge;
	logic [IDX_W-1:0]  q16, cen;
	logic              row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= CELL_RESET;
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_CELL_LENGTH: cell_q <= cfg_data;
				CFG_GRID_COLS:   cols_q <= cfg_data[CNT_W-1:0];
				CFG_GRID_ROWS:   rows_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// zero cell length acts as one lsb
	assign c_eff = (cell_q == '0) ? CELL_W'(1) : cell_q;

	assign px = pad_calc(sizex_q, c_eff);
	assign pz = pad_calc(sizez_q, c_eff);

	// k = floor(count/2) + 1
	assign k = (cmd.axis == AXIS_X) ? (CNT_W'(cols_q[CNT_W-1:1]) + 1'b1)
		: (CNT_W'(rows_q[CNT_W-1:1]) + 1'b1);

	assign num = {{(NUM_W-POS_W){((cmd.axis == AXIS_X) ? posx_q[POS_W-1] : posz_q[POS_W-1])}},
		((cmd.axis == AXIS_X) ? posx_q : posz_q)} + NUM_W'(prod_q);
	assign mag = num[NUM_W-1] ? MAG_W'(~num + 1'b1) : num[MAG_W-1:0];

	assign rem_sh = {rem_q, qd_q[MAG_W-1]};
	assign ge     = rem_sh >= {1'b0, c_eff};

	assign q16 = qd_q[IDX_W-1:0];
	assign cen = neg_q ? (~q16 + 1'b1) : q16;

	assign row_end = (coff_q == {padx_q, 1'b0});

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			type_q  <= in_type;
			posx_q  <= in_pos_x;
			posz_q  <= in_pos_z;
			sizex_q <= in_size_x;
			sizez_q <= in_size_z;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(k) * PROD_W'(c_eff);
			if (cmd.axis == AXIS_X) begin
				padx_q <= px.pad;
				padz_q <= type_q ? px.pad : pz.pad;
				clip_q <= px.clip | (type_q ? px.clip : pz.clip);
			end
		end
		if (cmd.load) begin
			neg_q <= num[NUM_W-1];
			rem_q <= '0;
			qd_q  <= mag;
		end
		if (cmd.step) begin
			rem_q <= ge ? CELL_W'(rem_sh - {1'b0, c_eff}) : rem_sh[CELL_W-1:0];
			qd_q  <= {qd_q[MAG_W-2:0], ge};
		end
		if (cmd.fin) begin
			if (cmd.axis == AXIS_X) begin
				colbase_q <= cen - IDX_W'(padx_q);
			end else begin
				row_q  <= cen - IDX_W'(padz_q);
				col_q  <= colbase_q;
				roff_q <= '0;
				coff_q <= '0;
			end
		end
		if (cmd.advance) begin
			if (row_end) begin
				coff_q <= '0;
				col_q  <= colbase_q;
				roff_q <= roff_q + 1'b1;
				row_q  <= row_q + 1'b1;
			end else begin
				coff_q <= coff_q + 1'b1;
				col_q  <= col_q + 1'b1;
			end
		end
	end

	assign stat.last = row_end && (roff_q == {padz_q, 1'b0});
	assign cell_row  = row_q;
	assign cell_col  = col_q;
	assign clipped   = clip_q;

endmodule

### hw/rtl/grid_footprint_rasterizer.sv
// grid_footprint_rasterizer: top level, joins the sequencer and the datapath
// depends on gfr_pkg, gfr_ctrl and gfr_dpath
//
// Takes one box or sphere footprint per input word and emits every grid cell
// it covers, row by row, with tlast on the final cell. Each footprint needs
// a setup of one multiply and a 37-step restoring division per axis through
// a single shared divider, then emits one cell per cycle while the sink is
// ready. A new footprint is taken only after the last cell of the previous
// one has been accepted.
// Config writes are only allowed while the block is idle.
module grid_footprint_rasterizer import gfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,  // pos_x, pos_z, size_x, size_z, zero fill
	input  logic                 s_tuser,  // req_type
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,  // cell_row, cell_col
	output logic                 m_tuser,  // clipped
	output logic                 m_tlast,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CELL_W-1:0]    cfg_data
);

	gfr_cmd_t         cmd;
	gfr_stat_t        stat;
	logic [IDX_W-1:0] cell_row, cell_col;

	gfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gfr_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_type   (s_tuser),
		.in_pos_x  (s_tdata[23:0]),
		.in_pos_z  (s_tdata[47:24]),
		.in_size_x (s_tdata[70:48]),
		.in_size_z (s_tdata[93:71]),
		.cmd       (cmd),
		.stat      (stat),
		.cell_row  (cell_row),
		.cell_col  (cell_col),
		.clipped   (m_tuser)
	);

	assign m_tdata = {cell_col, cell_row};
	assign m_tlast = stat.last;

endmodule

### hw/rtl/gfr_chk.sv
// gfr_chk: port-level checks of the grid footprint rasterizer
// depends on gfr_pkg; bound to grid_footprint_rasterizer below
module gfr_chk import gfr_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tuser,
	input logic             m_tlast
);

	// one footprint at a time
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while cells pending");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after taking a word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output word changed");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && $stable(m_tuser))
		else $error("footprint ended without tlast");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
		else $error("output after last word");

endmodule

bind grid_footprint_rasterizer gfr_chk u_gfr_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
